@@ sv/pvbp_pkg.sv @@
// pvbp_pkg: shared constants, types and the arctangent table of the bin processor
// depends on nothing; used by the cordic, phase update and core files of the block
package pvbp_pkg;

    // transform geometry
    localparam int FFT_SIZE     = 1024;
    localparam int NUM_CHANNELS = 2;
    localparam int BINS_PER_CH  = FFT_SIZE / 2 + 1;
    localparam int STATE_DEPTH  = NUM_CHANNELS * BINS_PER_CH;
    localparam int IDX_W        = $clog2(STATE_DEPTH);
    localparam int FFT_LOG      = $clog2(FFT_SIZE);
    localparam int EXP_SHIFT    = 16 - FFT_LOG;

    // datapath widths
    localparam int CW        = 36;
    localparam int MAG_W     = 34;
    localparam int DELTA_W   = 30;
    localparam int PROD_W    = CW + 18;
    localparam int ITERS     = 16;
    localparam int PER_STAGE = 2;
    localparam int CSTAGES   = ITERS / PER_STAGE;

    // arithmetic constants
    localparam int          INV_GAIN  = 39797;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
    localparam logic [11:0] HOP_RESET = 12'd256;

    // register indexes and mode codes
    localparam logic       REG_MODE     = 1'b0;
    localparam logic       REG_HOP      = 1'b1;
    localparam logic [1:0] MODE_ROBOT   = 2'd1;
    localparam logic [1:0] MODE_WHISPER = 2'd2;

    // control and side data that travel with each word
    typedef struct packed {
        logic               valid;
        logic               live;
        logic               edge_bin;
        logic               zero;
        logic [12:0]        bin;
        logic [IDX_W-1:0]   idx;
        logic [DELTA_W-1:0] expected;
        logic [15:0]        ratio;
    } meta_t;

    // arctangent of 2^-i in 1/65536 turns
    function automatic logic [15:0] atan_turn(input logic [3:0] i);
        logic [15:0] r;
        case (i)
            4'd0:    r = 16'd8192;
            4'd1:    r = 16'd4836;
            4'd2:    r = 16'd2555;
            4'd3:    r = 16'd1297;
            4'd4:    r = 16'd651;
            4'd5:    r = 16'd326;
            4'd6:    r = 16'd163;
            4'd7:    r = 16'd81;
            4'd8:    r = 16'd41;
            4'd9:    r = 16'd20;
            4'd10:   r = 16'd10;
            4'd11:   r = 16'd5;
            4'd12:   r = 16'd3;
            4'd13:   r = 16'd1;
            4'd14:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // clamp to the int32 range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ sv/pvbp_in_if.sv @@
// pvbp_in_if: valid/ready channel that carries one input bin word
// depends on nothing
interface pvbp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel;
    logic [12:0] bin;
    logic [31:0] re_in;
    logic [31:0] im_in;
    logic [15:0] pitch_ratio;

    modport source (output valid, channel, bin, re_in, im_in, pitch_ratio, input ready);
    modport sink (input valid, channel, bin, re_in, im_in, pitch_ratio, output ready);
endinterface

@@ sv/pvbp_out_if.sv @@
// pvbp_out_if: valid/ready channel that carries one resynthesized bin word
// depends on nothing
interface pvbp_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] bin_out;
    logic [31:0] re_out;
    logic [31:0] im_out;

    modport source (output valid, bin_out, re_out, im_out, input ready);
    modport sink (input valid, bin_out, re_out, im_out, output ready);
endinterface

@@ sv/pvbp_cordic_vec.sv @@
// pvbp_cordic_vec: pipelined vectoring cordic, two iterations per stage
// depends on pvbp_pkg
module pvbp_cordic_vec (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  pvbp_pkg::meta_t              meta_in,
    input  logic signed [pvbp_pkg::CW-1:0] x_in,
    input  logic signed [pvbp_pkg::CW-1:0] y_in,
    input  logic [15:0]                  z_in,
    output pvbp_pkg::meta_t              meta_out,
    output logic signed [pvbp_pkg::CW-1:0] x_out,
    output logic [15:0]                  z_out
);

    pvbp_pkg::meta_t                meta_reg [pvbp_pkg::CSTAGES];
    logic signed [pvbp_pkg::CW-1:0] x_reg    [pvbp_pkg::CSTAGES];
    logic signed [pvbp_pkg::CW-1:0] y_reg    [pvbp_pkg::CSTAGES];
    logic [15:0]                    z_reg    [pvbp_pkg::CSTAGES];

    for (genvar s = 0; s < pvbp_pkg::CSTAGES; s++)
    begin : g_stage
        pvbp_pkg::meta_t                m_src;
        logic signed [pvbp_pkg::CW-1:0] x_src, y_src, x_next, y_next;
        logic [15:0]                    z_src, z_next;

        if (s == 0)
        begin : g_first
            assign m_src = meta_in;
            assign x_src = x_in;
            assign y_src = y_in;
            assign z_src = z_in;
        end
        else
        begin : g_later
            assign m_src = meta_reg[s-1];
            assign x_src = x_reg[s-1];
            assign y_src = y_reg[s-1];
            assign z_src = z_reg[s-1];
        end

        // rotate toward the x axis, y sign picks the direction
        always_comb
        begin
            logic signed [pvbp_pkg::CW-1:0] xt, yt;
            int sh;
            x_next = x_src;
            y_next = y_src;
            z_next = z_src;
            for (int j = 0; j < pvbp_pkg::PER_STAGE; j++)
            begin
                sh = s * pvbp_pkg::PER_STAGE + j;
                xt = x_next;
                yt = y_next;
                if (!yt[pvbp_pkg::CW-1])
                begin
                    x_next = xt + (yt >>> sh);
                    y_next = yt - (xt >>> sh);
                    z_next = z_next + pvbp_pkg::atan_turn(4'(sh));
                end
                else
                begin
                    x_next = xt - (yt >>> sh);
                    y_next = yt + (xt >>> sh);
                    z_next = z_next - pvbp_pkg::atan_turn(4'(sh));
                end
            end
        end

        // stage control
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                meta_reg[s] <= '0;
            else if (en)
                meta_reg[s] <= m_src;
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s] <= x_next;
                y_reg[s] <= y_next;
                z_reg[s] <= z_next;
            end
        end
    end

    assign meta_out = meta_reg[pvbp_pkg::CSTAGES-1];
    assign x_out    = x_reg[pvbp_pkg::CSTAGES-1];
    assign z_out    = z_reg[pvbp_pkg::CSTAGES-1];

endmodule

@@ sv/pvbp_phase_upd.sv @@
// pvbp_phase_upd: per-bin phase state, unwrapping, synthesis phase update and noise lfsr
// depends on pvbp_pkg; holds the state memory and its clearing pass
module pvbp_phase_upd (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [1:0]                      mode,
    input  pvbp_pkg::meta_t                 meta_in,
    input  logic signed [pvbp_pkg::CW-1:0]  x_in,
    input  logic [15:0]                     z_in,
    output pvbp_pkg::meta_t                 meta_out,
    output logic [15:0]                     sp_out,
    output logic signed [pvbp_pkg::MAG_W-1:0] mag_out,
    output logic                            clr_busy
);

    // state memory: last phase in the upper half, synthesis phase in the lower
    logic [31:0] state_mem [pvbp_pkg::STATE_DEPTH];
    logic [31:0] rd_reg;

    logic                      clr_busy_reg;
    logic [pvbp_pkg::IDX_W-1:0] clr_cnt_reg;

    pvbp_pkg::meta_t p1_meta_reg, p2_meta_reg, p3_meta_reg, p4_meta_reg;
    logic [15:0] p1_ph_reg, p2_ph_reg, p3_ph_reg, p4_ph_reg;
    logic signed [pvbp_pkg::CW-1:0] p1_x_reg;
    logic signed [pvbp_pkg::PROD_W-1:0] p2_magp_reg;
    logic signed [pvbp_pkg::MAG_W-1:0] p3_mag_reg, p4_mag_reg;
    logic [pvbp_pkg::DELTA_W-1:0] p2_delta_reg, p3_prod_reg;
    logic [15:0] p2_syn_reg, p3_syn_reg, p4_sp_reg;
    logic [31:0] lfsr_reg;

    // write history beyond the output stage, for synthesis phase bypass
    logic                       h5_live_reg, h6_live_reg;
    logic [pvbp_pkg::IDX_W-1:0] h5_idx_reg, h6_idx_reg;
    logic [15:0]                h5_sp_reg, h6_sp_reg;

    logic [15:0]                  last_ph, dev, syn_old, sp_next;
    logic [pvbp_pkg::DELTA_W-1:0] delta_next, prod_next;
    logic signed [pvbp_pkg::PROD_W-1:0] magp_next;
    logic [31:0]                  lfsr_next;
    logic                         wr_en, lfsr_step;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == pvbp_pkg::IDX_W'(pvbp_pkg::STATE_DEPTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    assign clr_busy = clr_busy_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            state_mem[clr_cnt_reg] <= '0;
        else if (wr_en)
            state_mem[p3_meta_reg.idx] <= {p3_ph_reg, sp_next};
        if (en)
            rd_reg <= state_mem[meta_in.idx];
    end

    // last phase bypass from words not yet seen by the read
    always_comb
    begin
        if (p2_meta_reg.valid && p2_meta_reg.live && p2_meta_reg.idx == p1_meta_reg.idx)
            last_ph = p2_ph_reg;
        else if (p3_meta_reg.valid && p3_meta_reg.live && p3_meta_reg.idx == p1_meta_reg.idx)
            last_ph = p3_ph_reg;
        else if (p4_meta_reg.valid && p4_meta_reg.live && p4_meta_reg.idx == p1_meta_reg.idx)
            last_ph = p4_ph_reg;
        else
            last_ph = rd_reg[31:16];
    end

    // unwrapped phase advance and magnitude scaling
    always_comb
    begin
        dev        = p1_ph_reg - last_ph - p1_meta_reg.expected[15:0];
        delta_next = p1_meta_reg.expected + {{(pvbp_pkg::DELTA_W-16){dev[15]}}, dev};
        magp_next  = p1_x_reg * $signed(18'(pvbp_pkg::INV_GAIN));
    end

    // scaled advance with rounding, low bits only matter
    assign prod_next = pvbp_pkg::DELTA_W'(p2_delta_reg * {14'd0, p2_meta_reg.ratio})
                       + pvbp_pkg::DELTA_W'(8192);

    // synthesis phase bypass
    always_comb
    begin
        if (p4_meta_reg.valid && p4_meta_reg.live && p4_meta_reg.idx == p3_meta_reg.idx)
            syn_old = p4_sp_reg;
        else if (h5_live_reg && h5_idx_reg == p3_meta_reg.idx)
            syn_old = h5_sp_reg;
        else if (h6_live_reg && h6_idx_reg == p3_meta_reg.idx)
            syn_old = h6_sp_reg;
        else
            syn_old = p3_syn_reg;
    end

    // new synthesis phase by mode
    always_comb
    begin
        wr_en     = en && p3_meta_reg.valid && p3_meta_reg.live;
        lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? pvbp_pkg::LFSR_TAPS : 32'd0);
        lfsr_step = wr_en && (mode == pvbp_pkg::MODE_WHISPER);
        case (mode)
            pvbp_pkg::MODE_ROBOT:   sp_next = 16'd0;
            pvbp_pkg::MODE_WHISPER: sp_next = lfsr_next[31:16];
            default:                sp_next = syn_old + p3_prod_reg[29:14];
        endcase
    end

    // noise source
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lfsr_reg <= pvbp_pkg::LFSR_SEED;
        else if (lfsr_step)
            lfsr_reg <= lfsr_next;
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_meta_reg <= '0;
            p2_meta_reg <= '0;
            p3_meta_reg <= '0;
            p4_meta_reg <= '0;
            h5_live_reg <= 1'b0;
            h6_live_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_meta_reg <= meta_in;
            p2_meta_reg <= p1_meta_reg;
            p3_meta_reg <= p2_meta_reg;
            p4_meta_reg <= p3_meta_reg;
            h5_live_reg <= p4_meta_reg.valid && p4_meta_reg.live;
            h6_live_reg <= h5_live_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ph_reg    <= meta_in.zero ? 16'd0 : z_in;
            p1_x_reg     <= x_in;
            p2_ph_reg    <= p1_ph_reg;
            p2_delta_reg <= delta_next;
            p2_magp_reg  <= magp_next;
            p2_syn_reg   <= rd_reg[15:0];
            p3_ph_reg    <= p2_ph_reg;
            p3_prod_reg  <= prod_next;
            p3_mag_reg   <= p2_meta_reg.zero ? '0
                            : p2_magp_reg[16 +: pvbp_pkg::MAG_W];
            p3_syn_reg   <= p2_syn_reg;
            p4_ph_reg    <= p3_ph_reg;
            p4_sp_reg    <= sp_next;
            p4_mag_reg   <= p3_mag_reg;
            h5_idx_reg   <= p4_meta_reg.idx;
            h5_sp_reg    <= p4_sp_reg;
            h6_idx_reg   <= h5_idx_reg;
            h6_sp_reg    <= h5_sp_reg;
        end
    end

    assign meta_out = p4_meta_reg;
    assign sp_out   = p4_sp_reg;
    assign mag_out  = p4_mag_reg;

endmodule

@@ sv/pvbp_cordic_rot.sv @@
// pvbp_cordic_rot: pipelined rotating cordic, gain scaling and output selection
// depends on pvbp_pkg
module pvbp_cordic_rot (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  pvbp_pkg::meta_t                   meta_in,
    input  logic [15:0]                       sp_in,
    input  logic signed [pvbp_pkg::MAG_W-1:0] mag_in,
    output pvbp_pkg::meta_t                   meta_out,
    output logic [31:0]                       re_out,
    output logic [31:0]                       im_out
);

    pvbp_pkg::meta_t                   meta_reg [pvbp_pkg::CSTAGES];
    logic signed [pvbp_pkg::CW-1:0]    x_reg    [pvbp_pkg::CSTAGES];
    logic signed [pvbp_pkg::CW-1:0]    y_reg    [pvbp_pkg::CSTAGES];
    logic signed [15:0]                z_reg    [pvbp_pkg::CSTAGES];
    logic signed [pvbp_pkg::MAG_W-1:0] mag_reg  [pvbp_pkg::CSTAGES];

    pvbp_pkg::meta_t                   sc_meta_reg;
    logic signed [pvbp_pkg::PROD_W-1:0] sc_x_reg, sc_y_reg;
    logic signed [pvbp_pkg::MAG_W-1:0] sc_mag_reg;

    logic signed [pvbp_pkg::CW-1:0]    mag_ext, x_fold;
    logic signed [15:0]                z_fold;

    // fold angles beyond a quarter turn by half a turn
    always_comb
    begin
        mag_ext = pvbp_pkg::CW'(mag_in);
        x_fold  = mag_ext;
        z_fold  = $signed(sp_in);
        if ($signed(sp_in) > 16'sd16384)
        begin
            x_fold = -mag_ext;
            z_fold = $signed(sp_in) - 16'sd32767 - 16'sd1;
        end
        else if ($signed(sp_in) < -16'sd16384)
        begin
            x_fold = -mag_ext;
            z_fold = $signed(sp_in) + 16'sd32767 + 16'sd1;
        end
    end

    for (genvar s = 0; s < pvbp_pkg::CSTAGES; s++)
    begin : g_stage
        pvbp_pkg::meta_t                   m_src;
        logic signed [pvbp_pkg::CW-1:0]    x_src, y_src, x_next, y_next;
        logic signed [15:0]                z_src, z_next;
        logic signed [pvbp_pkg::MAG_W-1:0] g_src;

        if (s == 0)
        begin : g_first
            assign m_src = meta_in;
            assign x_src = x_fold;
            assign y_src = '0;
            assign z_src = z_fold;
            assign g_src = mag_in;
        end
        else
        begin : g_later
            assign m_src = meta_reg[s-1];
            assign x_src = x_reg[s-1];
            assign y_src = y_reg[s-1];
            assign z_src = z_reg[s-1];
            assign g_src = mag_reg[s-1];
        end

        // rotate by the residual angle, its sign picks the direction
        always_comb
        begin
            logic signed [pvbp_pkg::CW-1:0] xt, yt;
            int sh;
            x_next = x_src;
            y_next = y_src;
            z_next = z_src;
            for (int j = 0; j < pvbp_pkg::PER_STAGE; j++)
            begin
                sh = s * pvbp_pkg::PER_STAGE + j;
                xt = x_next;
                yt = y_next;
                if (!z_next[15])
                begin
                    x_next = xt - (yt >>> sh);
                    y_next = yt + (xt >>> sh);
                    z_next = z_next - $signed(pvbp_pkg::atan_turn(4'(sh)));
                end
                else
                begin
                    x_next = xt + (yt >>> sh);
                    y_next = yt - (xt >>> sh);
                    z_next = z_next + $signed(pvbp_pkg::atan_turn(4'(sh)));
                end
            end
        end

        // stage control
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                meta_reg[s] <= '0;
            else if (en)
                meta_reg[s] <= m_src;
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]   <= x_next;
                y_reg[s]   <= y_next;
                z_reg[s]   <= z_next;
                mag_reg[s] <= g_src;
            end
        end
    end

    // gain correction stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_meta_reg <= '0;
        else if (en)
            sc_meta_reg <= meta_reg[pvbp_pkg::CSTAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_x_reg   <= x_reg[pvbp_pkg::CSTAGES-1] * $signed(18'(pvbp_pkg::INV_GAIN));
            sc_y_reg   <= y_reg[pvbp_pkg::CSTAGES-1] * $signed(18'(pvbp_pkg::INV_GAIN));
            sc_mag_reg <= mag_reg[pvbp_pkg::CSTAGES-1];
        end
    end

    // out of range gives zero, dc and nyquist give the bare magnitude
    always_comb
    begin
        meta_out = sc_meta_reg;
        if (!sc_meta_reg.live)
        begin
            re_out = 32'd0;
            im_out = 32'd0;
        end
        else if (sc_meta_reg.edge_bin)
        begin
            re_out = pvbp_pkg::sat32(64'(sc_mag_reg));
            im_out = 32'd0;
        end
        else
        begin
            re_out = pvbp_pkg::sat32(64'(sc_x_reg >>> 16));
            im_out = pvbp_pkg::sat32(64'(sc_y_reg >>> 16));
        end
    end

endmodule

@@ sv/phase_vocoder_bin_processor_core.sv @@
// phase vocoder bin processor: input stage, vectoring cordic, phase update, rotating cordic,
// gain stage, output register; throughput one word per cycle; a stalled output holds the
// whole pipeline in place; the per-bin phase state (1026 entries) is cleared by a pass after
// reset, during which no word is accepted; configuration writes are taken at any time
// reset values: mode pitch shift, hop size 256, noise lfsr seed 0xACE1
// depends on pvbp_pkg, pvbp_in_if, pvbp_out_if, pvbp_cordic_vec, pvbp_phase_upd, pvbp_cordic_rot
module phase_vocoder_bin_processor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_data,
    pvbp_in_if.sink     din,
    pvbp_out_if.source  dout
);

    logic [1:0]  mode_reg;
    logic [11:0] hop_reg;

    logic en, accept, clr_busy;

    pvbp_pkg::meta_t                s0_meta_reg, s0_meta_next;
    logic signed [pvbp_pkg::CW-1:0] s0_x_reg, s0_y_reg, s0_x_next, s0_y_next;
    logic [15:0]                    s0_z_reg, s0_z_next;

    pvbp_pkg::meta_t                   vec_meta, ph_meta, rot_meta;
    logic signed [pvbp_pkg::CW-1:0]    vec_x;
    logic [15:0]                       vec_z, sp;
    logic signed [pvbp_pkg::MAG_W-1:0] mag;
    logic [31:0]                       rot_re, rot_im;

    logic        out_valid_reg;
    logic [12:0] out_bin_reg;
    logic [31:0] out_re_reg, out_im_reg;

    logic signed [pvbp_pkg::CW-1:0] re_ext, im_ext;
    logic [31:0] idx_full, exp_full;
    logic [24:0] hop_bin;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 2'd0;
            hop_reg  <= pvbp_pkg::HOP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pvbp_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                pvbp_pkg::REG_HOP:  hop_reg  <= cfg_data;
                default:            mode_reg <= mode_reg;
            endcase
        end
    end

    // pipeline advance and input handshake
    assign en        = !out_valid_reg || dout.ready;
    assign din.ready = en && !clr_busy;
    assign accept    = din.valid && din.ready;

    // input word decode and half-turn prefold
    always_comb
    begin
        re_ext   = pvbp_pkg::CW'($signed(din.re_in));
        im_ext   = pvbp_pkg::CW'($signed(din.im_in));
        idx_full = 32'(din.channel) * 32'(pvbp_pkg::BINS_PER_CH) + 32'(din.bin);
        hop_bin  = 25'(hop_reg) * 25'(din.bin);
        exp_full = {7'd0, hop_bin} << pvbp_pkg::EXP_SHIFT;

        s0_meta_next.valid    = accept;
        s0_meta_next.live     = (32'(din.channel) < 32'(pvbp_pkg::NUM_CHANNELS))
                                && (32'(din.bin) <= 32'(pvbp_pkg::FFT_SIZE / 2));
        s0_meta_next.edge_bin = (din.bin == 13'd0)
                                || (32'(din.bin) == 32'(pvbp_pkg::FFT_SIZE / 2));
        s0_meta_next.zero     = (din.re_in == 32'd0) && (din.im_in == 32'd0);
        s0_meta_next.bin      = din.bin;
        s0_meta_next.idx      = idx_full[pvbp_pkg::IDX_W-1:0];
        s0_meta_next.expected = exp_full[pvbp_pkg::DELTA_W-1:0];
        s0_meta_next.ratio    = din.pitch_ratio;

        if (din.re_in[31])
        begin
            s0_x_next = -re_ext;
            s0_y_next = -im_ext;
            s0_z_next = 16'h8000;
        end
        else
        begin
            s0_x_next = re_ext;
            s0_y_next = im_ext;
            s0_z_next = 16'h0000;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_meta_reg <= '0;
        else if (en)
            s0_meta_reg <= s0_meta_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg <= s0_x_next;
            s0_y_reg <= s0_y_next;
            s0_z_reg <= s0_z_next;
        end
    end

    // magnitude and phase measurement
    pvbp_cordic_vec u_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .meta_in  (s0_meta_reg),
        .x_in     (s0_x_reg),
        .y_in     (s0_y_reg),
        .z_in     (s0_z_reg),
        .meta_out (vec_meta),
        .x_out    (vec_x),
        .z_out    (vec_z)
    );

    // phase state and synthesis phase
    pvbp_phase_upd u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .mode     (mode_reg),
        .meta_in  (vec_meta),
        .x_in     (vec_x),
        .z_in     (vec_z),
        .meta_out (ph_meta),
        .sp_out   (sp),
        .mag_out  (mag),
        .clr_busy (clr_busy)
    );

    // resynthesis
    pvbp_cordic_rot u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .meta_in  (ph_meta),
        .sp_in    (sp),
        .mag_in   (mag),
        .meta_out (rot_meta),
        .re_out   (rot_re),
        .im_out   (rot_im)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= rot_meta.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_bin_reg <= rot_meta.bin;
            out_re_reg  <= rot_re;
            out_im_reg  <= rot_im;
        end
    end

    assign dout.valid   = out_valid_reg;
    assign dout.bin_out = out_bin_reg;
    assign dout.re_out  = out_re_reg;
    assign dout.im_out  = out_im_reg;

endmodule
